@@ hw/rtl/kdpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpc_pkg: shared types and constants for the key debounce classifier
// Field widths, register indexes, event codes and reset values used by the
// channel interfaces, the register file and the classifier datapath.
// ----------------------------------------------------------------------------
package kdpc_pkg;

	// Payload field widths
	localparam int KEY_W     = 4;
	localparam int EVENT_W   = 2;
	localparam int MASK_W    = 9;
	localparam int NOW_W     = 32;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE     = 2'd2;

	// Register reset values
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd500;
	localparam logic [CFG_W-1:0] IDLE_RST     = 16'd1000;

	// Event codes
	localparam logic [EVENT_W-1:0] EV_ONE_CLICK = 2'd0;
	localparam logic [EVENT_W-1:0] EV_SHORT     = 2'd1;
	localparam logic [EVENT_W-1:0] EV_LONG      = 2'd2;

	// Key code for "no key" / release
	localparam logic [KEY_W-1:0] KEY_NONE = 4'd0;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] repeat_threshold_ms;
		logic [CFG_W-1:0] idle_ms;
	} kdpc_cfg_t;

	// Control part of the tracker state
	typedef struct packed {
		logic [KEY_W-1:0]   cand_key;
		logic [KEY_W-1:0]   last_key;
		logic [EVENT_W-1:0] last_event;
		logic               release_pending;
	} kdpc_ctrl_t;

endpackage

@@ hw/rtl/kdpc_channels_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpc channel interfaces
// Valid/ready channels for poll samples in and classified key events out.
// ----------------------------------------------------------------------------
interface kdpc_sample_if;
	logic                         valid;
	logic                         ready;
	logic [kdpc_pkg::MASK_W-1:0]  pressed_mask;
	logic [kdpc_pkg::NOW_W-1:0]   now_ms;

	modport source (output valid, output pressed_mask, output now_ms, input ready);
	modport sink   (input valid, input pressed_mask, input now_ms, output ready);
endinterface

interface kdpc_result_if;
	logic                          valid;
	logic                          ready;
	logic [kdpc_pkg::KEY_W-1:0]    key_code;
	logic [kdpc_pkg::EVENT_W-1:0]  press_event;

	modport source (output valid, output key_code, output press_event, input ready);
	modport sink   (input valid, input key_code, input press_event, output ready);
endinterface

@@ hw/rtl/key_debounce_press_classifier_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_core: key debounce and press classifier
// Debounces a polled key mask and reports one-click, short-press, long-press
// and release events.
//
//   Channel   Dir   Payload                       Transaction
//   sample    in    pressed_mask[8:0], now_ms     valid & ready
//   result    out   key_code[3:0], press_event    valid & ready
//   cfg       in    cfg_idx[1:0], cfg_wdata[15:0] cfg_we (no handshake)
//
// One sample per cycle sustained while the result side drains; a sample passes
// through the input register, then classification into the result register.
// Reset restores the tracker state and the register defaults at once.
// A sample that yields a result waits in the input stage while the result
// register is full and not being drained, and holds off the next sample;
// with the result side always ready, no sample ever stalls.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier_core #(
	parameter int NUM_KEYS  = 9,
	parameter int TIME_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	kdpc_sample_if.sink                    sample,
	kdpc_result_if.source                  result,
	input  logic                           cfg_we,
	input  logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [kdpc_pkg::CFG_W-1:0]     cfg_wdata
);

	kdpc_pkg::kdpc_cfg_t           cfg;

	logic                          valid_s1;
	logic [kdpc_pkg::MASK_W-1:0]   mask_s1;
	logic [TIME_BITS-1:0]          now_s1;

	kdpc_pkg::kdpc_ctrl_t          ctrl_q;
	logic [TIME_BITS-1:0]          cand_start_q;
	logic [TIME_BITS-1:0]          last_accept_q;

	kdpc_pkg::kdpc_ctrl_t          ctrl_nxt;
	logic [TIME_BITS-1:0]          cand_start_nxt;
	logic [TIME_BITS-1:0]          last_accept_nxt;
	logic                          res_valid;
	logic [kdpc_pkg::KEY_W-1:0]    res_key;
	logic [kdpc_pkg::EVENT_W-1:0]  res_event;

	logic                          out_valid_q;
	logic [kdpc_pkg::KEY_W-1:0]    out_key_q;
	logic [kdpc_pkg::EVENT_W-1:0]  out_event_q;

	logic                          s1_adv;
	logic                          in_fire;

	kdpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Stage 1 leaves when it makes no result or the result slot frees up
	assign s1_adv  = valid_s1 && (!res_valid || !out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || s1_adv;
	assign in_fire = sample.valid && sample.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mask_s1 <= sample.pressed_mask;
			now_s1  <= sample.now_ms[TIME_BITS-1:0];
		end
	end

	kdpc_classify #(
		.NUM_KEYS  (NUM_KEYS),
		.TIME_BITS (TIME_BITS)
	) u_classify (
		.pressed_mask    (mask_s1),
		.now             (now_s1),
		.cfg             (cfg),
		.ctrl            (ctrl_q),
		.cand_start      (cand_start_q),
		.last_accept     (last_accept_q),
		.ctrl_nxt        (ctrl_nxt),
		.cand_start_nxt  (cand_start_nxt),
		.last_accept_nxt (last_accept_nxt),
		.res_valid       (res_valid),
		.res_key         (res_key),
		.res_event       (res_event)
	);

	// Tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q        <= '0;
			cand_start_q  <= '0;
			last_accept_q <= '0;
		end else if (s1_adv) begin
			ctrl_q        <= ctrl_nxt;
			cand_start_q  <= cand_start_nxt;
			last_accept_q <= last_accept_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res_valid) begin
			out_key_q   <= res_key;
			out_event_q <= res_event;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.key_code    = out_key_q;
	assign result.press_event = out_event_q;

endmodule

@@ hw/rtl/kdpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpc_cfg_regs: configuration register file
// Three 16-bit timing registers written through a plain write port;
// writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module kdpc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kdpc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [kdpc_pkg::CFG_W-1:0]     cfg_wdata,
	output kdpc_pkg::kdpc_cfg_t            cfg
);

	kdpc_pkg::kdpc_cfg_t cfg_q;

	// Register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms         <= kdpc_pkg::DEBOUNCE_RST;
			cfg_q.repeat_threshold_ms <= kdpc_pkg::REPEAT_RST;
			cfg_q.idle_ms             <= kdpc_pkg::IDLE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				kdpc_pkg::CFG_DEBOUNCE: cfg_q.debounce_ms         <= cfg_wdata;
				kdpc_pkg::CFG_REPEAT:   cfg_q.repeat_threshold_ms <= cfg_wdata;
				kdpc_pkg::CFG_IDLE:     cfg_q.idle_ms             <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/kdpc_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdpc_classify: single-pass debounce and press classification
// From one registered sample and the current tracker state, computes the
// next state and at most one result (key acceptance or release).
// ----------------------------------------------------------------------------
module kdpc_classify #(
	parameter int NUM_KEYS  = 9,
	parameter int TIME_BITS = 32
) (
	input  logic [kdpc_pkg::MASK_W-1:0]   pressed_mask,
	input  logic [TIME_BITS-1:0]          now,
	input  kdpc_pkg::kdpc_cfg_t           cfg,
	input  kdpc_pkg::kdpc_ctrl_t          ctrl,
	input  logic [TIME_BITS-1:0]          cand_start,
	input  logic [TIME_BITS-1:0]          last_accept,
	output kdpc_pkg::kdpc_ctrl_t          ctrl_nxt,
	output logic [TIME_BITS-1:0]          cand_start_nxt,
	output logic [TIME_BITS-1:0]          last_accept_nxt,
	output logic                          res_valid,
	output logic [kdpc_pkg::KEY_W-1:0]    res_key,
	output logic [kdpc_pkg::EVENT_W-1:0]  res_event
);

	// Only keys that exist and have a mask bit are scanned
	localparam int SCAN_KEYS = (NUM_KEYS < kdpc_pkg::MASK_W) ? NUM_KEYS : kdpc_pkg::MASK_W;
	// Compare width covers elapsed time and the 17-bit idle+debounce sum
	localparam int CMP_W = (TIME_BITS > kdpc_pkg::CFG_W + 1) ? TIME_BITS : kdpc_pkg::CFG_W + 1;

	logic [SCAN_KEYS-1:0]          keys;
	logic [kdpc_pkg::KEY_W-1:0]    low_key;
	logic [kdpc_pkg::KEY_W-1:0]    cand_eff;
	logic [TIME_BITS-1:0]          start_eff;
	logic                          cand_held;
	logic [TIME_BITS-1:0]          el_start;
	logic [TIME_BITS-1:0]          el_last;
	logic [CMP_W-1:0]              el_start_c;
	logic [CMP_W-1:0]              el_last_c;
	logic [CMP_W-1:0]              idle_deb;
	logic                          accepted;
	logic                          released;
	logic [kdpc_pkg::EVENT_W-1:0]  ev;
	logic [kdpc_pkg::KEY_W-1:0]    cand_after;

	assign keys = pressed_mask[SCAN_KEYS-1:0];

	// Lowest pressed key (priority encoder)
	always_comb begin
		low_key = kdpc_pkg::KEY_NONE;
		for (int i = SCAN_KEYS - 1; i >= 0; i--) begin
			if (keys[i]) low_key = kdpc_pkg::KEY_W'(i + 1);
		end
	end

	// Candidate pick: only when no candidate is held
	assign cand_eff  = (ctrl.cand_key == kdpc_pkg::KEY_NONE) ? low_key : ctrl.cand_key;
	assign start_eff = (ctrl.cand_key == kdpc_pkg::KEY_NONE && low_key != kdpc_pkg::KEY_NONE)
		? now : cand_start;

	// Is the candidate key still pressed
	always_comb begin
		cand_held = 1'b0;
		for (int i = 0; i < SCAN_KEYS; i++) begin
			if (keys[i] && cand_eff == kdpc_pkg::KEY_W'(i + 1)) cand_held = 1'b1;
		end
	end

	// Wrapping elapsed times
	assign el_start   = now - start_eff;
	assign el_last    = now - last_accept;
	assign el_start_c = CMP_W'(el_start);
	assign el_last_c  = CMP_W'(el_last);
	assign idle_deb   = CMP_W'(cfg.idle_ms) + CMP_W'(cfg.debounce_ms);

	// Acceptance and event code
	assign accepted = cand_held && (el_start_c >= CMP_W'(cfg.debounce_ms));

	always_comb begin
		if (cand_eff != ctrl.last_key) begin
			ev = kdpc_pkg::EV_ONE_CLICK;
		end else if (el_last_c < CMP_W'(cfg.repeat_threshold_ms)) begin
			ev = kdpc_pkg::EV_LONG;
		end else begin
			ev = kdpc_pkg::EV_SHORT;
		end
	end

	// Release report after idle plus debounce with no acceptance
	assign released = ctrl.release_pending && !accepted && (el_last_c > idle_deb);

	// Candidate clear on accept/release, then drop after idle time
	always_comb begin
		cand_after = (accepted || released) ? kdpc_pkg::KEY_NONE : cand_eff;
		if (cand_after != kdpc_pkg::KEY_NONE && el_start_c >= CMP_W'(cfg.idle_ms)) begin
			cand_after = kdpc_pkg::KEY_NONE;
		end
	end

	// Next state
	always_comb begin
		ctrl_nxt          = ctrl;
		ctrl_nxt.cand_key = cand_after;
		if (accepted) begin
			ctrl_nxt.last_key        = cand_eff;
			ctrl_nxt.last_event      = ev;
			ctrl_nxt.release_pending = 1'b1;
		end else if (released) begin
			ctrl_nxt.release_pending = 1'b0;
		end
	end

	assign cand_start_nxt  = start_eff;
	assign last_accept_nxt = accepted ? now : last_accept;

	// Result
	assign res_valid = accepted || released;
	assign res_key   = accepted ? cand_eff : kdpc_pkg::KEY_NONE;
	assign res_event = accepted ? ev : ctrl.last_event;

endmodule
